### rtl/core/mcc_pkg.sv
// Shared widths, register indexes and table entry type for the coin change block.
package mcc_pkg;

    localparam int TGT_W    = 6;
    localparam int COIN_W   = 6;
    localparam int LEN_W    = 7;
    localparam int CHOICE_W = 3;
    localparam int CNT_W    = 3;
    localparam int IDX_W    = 3;
    localparam int NUM_COINS = 6;

    localparam logic [LEN_W-1:0] UNREACH = 7'd127;

    localparam logic [IDX_W-1:0] CFG_COIN_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] CFG_COIN_FIRST = 3'd1;

    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [CHOICE_W-1:0] choice;
    } dp_entry_t;

endpackage

### rtl/core/min_coin_change_sequence.sv
// Top level: minimum coin change, DP table build, traceback and sequence emission.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  in      | in_valid, in_ready, target                      | in
//  out     | out_valid, out_ready, coin_value, found,        | out
//          | sequence_length, last                           |
//  cfg     | cfg_wr_en, cfg_index, cfg_data                  | in
//
// Target t with n coins in use: the table is built row by row (one table RAM read per
// coin, one write per row), traced back into the stack RAM, then popped out coin by coin.
// Zero or out-of-range targets skip the table and answer with a single item.
// in_ready is high only between queries; a stalled output holds the sequencer.
// Reset clears control state and sets coin_count and every coin to one.
module min_coin_change_sequence
    import mcc_pkg::*;
#(
    parameter int MAX_TARGET = 63,
    parameter int MAX_COINS  = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TGT_W-1:0]  target,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [COIN_W-1:0] coin_value,
    output logic              found,
    output logic [TGT_W-1:0]  sequence_length,
    output logic              last,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [COIN_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_TARGET + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int DP_W  = $bits(dp_entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_TRACE,
        ST_POP_RD,
        ST_POP_OUT,
        ST_SINGLE
    } state_t;

    // configuration
    logic [CNT_W-1:0]  coin_count_reg;
    logic [COIN_W-1:0] coin_reg [NUM_COINS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_count_reg <= CNT_W'(1);
            for (int j = 0; j < NUM_COINS; j++)
            begin
                coin_reg[j] <= COIN_W'(1);
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_COIN_COUNT)
            begin
                coin_count_reg <= cfg_data[CNT_W-1:0];
            end
            for (int j = 0; j < NUM_COINS; j++)
            begin
                if (cfg_index == CFG_COIN_FIRST + IDX_W'(j))
                begin
                    coin_reg[j] <= cfg_data;
                end
            end
        end
    end

    // sequencer registers
    state_t            state_reg,     state_next;
    logic [AW-1:0]     t_reg,         t_next;
    logic [CNT_W-1:0]  n_reg,         n_next;
    logic [AW-1:0]     m_reg,         m_next;
    logic [IDX_W-1:0]  i_reg,         i_next;
    logic [LEN_W-1:0]  best_reg,      best_next;
    logic [CHOICE_W-1:0] choice_reg,  choice_next;
    logic              pend_vld_reg,  pend_vld_next;
    logic [CHOICE_W-1:0] pend_idx_reg, pend_idx_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic [AW-1:0]     pos_reg,       pos_next;
    logic [AW-1:0]     k_reg,         k_next;
    logic              first_reg,     first_next;
    logic              single_found_reg, single_found_next;
    logic              out_valid_reg, out_valid_next;
    logic [COIN_W-1:0] coin_value_reg, coin_value_next;
    logic              found_reg,     found_next;
    logic [TGT_W-1:0]  seq_len_reg,   seq_len_next;
    logic              last_reg,      last_next;

    // memories
    logic          dp_wr_en;
    logic [AW-1:0] dp_wr_addr;
    dp_entry_t     dp_wr_data;
    logic [AW-1:0] dp_rd_addr;
    dp_entry_t     dp_rd_data;

    logic              stk_wr_en;
    logic [AW-1:0]     stk_wr_addr;
    logic [COIN_W-1:0] stk_wr_data;
    logic [AW-1:0]     stk_rd_addr;
    logic [COIN_W-1:0] stk_rd_data;

    mcc_ram #(
        .WIDTH (DP_W),
        .DEPTH (DEPTH)
    ) u_dp_ram (
        .clk     (clk),
        .wr_en   (dp_wr_en),
        .wr_addr (dp_wr_addr),
        .wr_data (dp_wr_data),
        .rd_addr (dp_rd_addr),
        .rd_data (dp_rd_data)
    );

    mcc_ram #(
        .WIDTH (COIN_W),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // datapath helpers
    logic [CNT_W-1:0]    n_eff;
    logic [COIN_W-1:0]   build_coin;
    logic                build_usable;
    logic [COIN_W-1:0]   m_ext;
    logic [LEN_W-1:0]    cand_len;
    logic                cand_better;
    logic [LEN_W-1:0]    best_c;
    logic [CHOICE_W-1:0] choice_c;
    logic [CHOICE_W-1:0] tr_sel;
    logic [CHOICE_W-1:0] tr_idx;
    logic [COIN_W-1:0]   tr_coin;
    logic [COIN_W-1:0]   pos_ext;
    logic [AW-1:0]       tr_pos_next;
    logic [AW:0]         k_inc;
    logic                tr_done;
    logic                out_free;
    logic                in_fire;

    assign n_eff = (coin_count_reg > CNT_W'(MAX_COINS)) ? CNT_W'(MAX_COINS) : coin_count_reg;

    assign build_coin   = (i_reg < IDX_W'(NUM_COINS)) ? coin_reg[i_reg] : '0;
    assign m_ext        = COIN_W'(m_reg);
    assign build_usable = (build_coin != '0) && (build_coin <= m_ext);

    assign cand_len    = dp_rd_data.len + LEN_W'(1);
    assign cand_better = pend_vld_reg && (dp_rd_data.len != UNREACH) && (cand_len < best_reg);
    assign best_c      = cand_better ? cand_len : best_reg;
    assign choice_c    = cand_better ? pend_idx_reg : choice_reg;

    assign tr_sel  = first_reg ? choice_reg : dp_rd_data.choice;
    assign tr_idx  = (tr_sel >= CHOICE_W'(NUM_COINS)) ? tr_sel - CHOICE_W'(NUM_COINS) : tr_sel;
    assign tr_coin = coin_reg[tr_idx];
    assign pos_ext = COIN_W'(pos_reg);
    assign tr_pos_next = (tr_coin <= pos_ext) ? AW'(pos_ext - tr_coin) : '0;
    assign k_inc   = {1'b0, k_reg} + (AW+1)'(1);
    assign tr_done = (tr_pos_next == '0) || (LEN_W'(k_inc) >= len_reg);

    assign out_free = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        t_next            = t_reg;
        n_next            = n_reg;
        m_next            = m_reg;
        i_next            = i_reg;
        best_next         = best_reg;
        choice_next       = choice_reg;
        pend_vld_next     = pend_vld_reg;
        pend_idx_next     = pend_idx_reg;
        len_next          = len_reg;
        pos_next          = pos_reg;
        k_next            = k_reg;
        first_next        = first_reg;
        single_found_next = single_found_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        coin_value_next   = coin_value_reg;
        found_next        = found_reg;
        seq_len_next      = seq_len_reg;
        last_next         = last_reg;

        dp_wr_en    = 1'b0;
        dp_wr_addr  = m_reg;
        dp_wr_data  = '{len: best_c, choice: choice_c};
        dp_rd_addr  = AW'(m_ext - build_coin);
        stk_wr_en   = 1'b0;
        stk_wr_addr = k_reg;
        stk_wr_data = tr_coin;
        stk_rd_addr = k_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    t_next        = target[AW-1:0];
                    n_next        = n_eff;
                    m_next        = AW'(1);
                    i_next        = '0;
                    best_next     = UNREACH;
                    choice_next   = '0;
                    pend_vld_next = 1'b0;
                    if (target == '0)
                    begin
                        single_found_next = 1'b1;
                        state_next        = ST_SINGLE;
                    end
                    else if (target > TGT_W'(MAX_TARGET))
                    begin
                        single_found_next = 1'b0;
                        state_next        = ST_SINGLE;
                    end
                    else
                    begin
                        dp_wr_en   = 1'b1;
                        dp_wr_addr = '0;
                        dp_wr_data = '{len: '0, choice: '0};
                        state_next = ST_BUILD;
                    end
                end
            end

            ST_BUILD:
            begin
                if (i_reg < n_reg)
                begin
                    best_next     = best_c;
                    choice_next   = choice_c;
                    pend_vld_next = build_usable;
                    pend_idx_next = i_reg;
                    i_next        = i_reg + IDX_W'(1);
                end
                else
                begin
                    dp_wr_en      = 1'b1;
                    pend_vld_next = 1'b0;
                    i_next        = '0;
                    best_next     = UNREACH;
                    choice_next   = '0;
                    if (m_reg == t_reg)
                    begin
                        len_next    = best_c;
                        choice_next = choice_c;
                        pos_next    = t_reg;
                        k_next      = '0;
                        first_next  = 1'b1;
                        if (best_c == UNREACH)
                        begin
                            single_found_next = 1'b0;
                            state_next        = ST_SINGLE;
                        end
                        else
                        begin
                            state_next = ST_TRACE;
                        end
                    end
                    else
                    begin
                        m_next = m_reg + AW'(1);
                    end
                end
            end

            ST_TRACE:
            begin
                stk_wr_en  = 1'b1;
                dp_rd_addr = tr_pos_next;
                pos_next   = tr_pos_next;
                first_next = 1'b0;
                k_next     = k_inc[AW-1:0];
                if (tr_done)
                begin
                    state_next = ST_POP_RD;
                end
            end

            ST_POP_RD:
            begin
                stk_rd_addr = k_reg - AW'(1);
                k_next      = k_reg - AW'(1);
                state_next  = ST_POP_OUT;
            end

            ST_POP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    coin_value_next = stk_rd_data;
                    found_next      = 1'b1;
                    seq_len_next    = len_reg[TGT_W-1:0];
                    last_next       = (k_reg == '0);
                    state_next      = (k_reg == '0) ? ST_IDLE : ST_POP_RD;
                end
            end

            ST_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    coin_value_next = '0;
                    found_next      = single_found_reg;
                    seq_len_next    = '0;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            t_reg            <= '0;
            n_reg            <= '0;
            m_reg            <= '0;
            i_reg            <= '0;
            best_reg         <= UNREACH;
            choice_reg       <= '0;
            pend_vld_reg     <= 1'b0;
            pend_idx_reg     <= '0;
            len_reg          <= '0;
            pos_reg          <= '0;
            k_reg            <= '0;
            first_reg        <= 1'b0;
            single_found_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            coin_value_reg   <= '0;
            found_reg        <= 1'b0;
            seq_len_reg      <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            t_reg            <= t_next;
            n_reg            <= n_next;
            m_reg            <= m_next;
            i_reg            <= i_next;
            best_reg         <= best_next;
            choice_reg       <= choice_next;
            pend_vld_reg     <= pend_vld_next;
            pend_idx_reg     <= pend_idx_next;
            len_reg          <= len_next;
            pos_reg          <= pos_next;
            k_reg            <= k_next;
            first_reg        <= first_next;
            single_found_reg <= single_found_next;
            out_valid_reg    <= out_valid_next;
            coin_value_reg   <= coin_value_next;
            found_reg        <= found_next;
            seq_len_reg      <= seq_len_next;
            last_reg         <= last_next;
        end
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign coin_value      = coin_value_reg;
    assign found           = found_reg;
    assign sequence_length = seq_len_reg;
    assign last            = last_reg;

endmodule

### rtl/core/mcc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### tb/mcc_checker.sv
// Checker for the coin change block: predicts the coin items of each query and compares them.
`timescale 1ns / 100ps

module mcc_checker
    import mcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [TGT_W-1:0]  target,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [COIN_W-1:0] coin_value,
    input  logic              found,
    input  logic [TGT_W-1:0]  sequence_length,
    input  logic              last,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [COIN_W-1:0] cfg_data,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [COIN_W-1:0] coin;
        logic              found;
        logic [TGT_W-1:0]  length;
        logic              last;
    } coin_item_t;

    logic [CNT_W-1:0]  coins_in_use;
    logic [COIN_W-1:0] coin_val [NUM_COINS];
    coin_item_t        change_due [$];

    function automatic void add_item(
        input logic [COIN_W-1:0] coin,
        input logic              fnd,
        input logic [TGT_W-1:0]  length,
        input logic              lst
    );
        coin_item_t item;
        item.coin   = coin;
        item.found  = fnd;
        item.length = length;
        item.last   = lst;
        change_due.push_back(item);
    endfunction

    // Fewest-coins table over 0..sum, lowest index wins a tie, then trace back from sum.
    function automatic void plan_change(input logic [TGT_W-1:0] sum);
        int fewest [64];
        int pick   [64];
        int trail  [$];
        int n, m, i, best, choice, rest, pos, c;
        n = (coins_in_use > NUM_COINS) ? NUM_COINS : int'(coins_in_use);
        if (sum == 0) begin
            add_item('0, 1'b1, '0, 1'b1);
            return;
        end
        fewest[0] = 0;
        pick[0]   = 0;
        for (m = 1; m <= sum; m++) begin
            best   = UNREACH;
            choice = 0;
            for (i = 0; i < n; i++) begin
                if (coin_val[i] != 0 && int'(coin_val[i]) <= m) begin
                    rest = fewest[m - int'(coin_val[i])];
                    if (rest != UNREACH && rest + 1 < best) begin
                        best   = rest + 1;
                        choice = i;
                    end
                end
            end
            fewest[m] = best;
            pick[m]   = choice;
        end
        if (fewest[sum] == UNREACH) begin
            add_item('0, 1'b0, '0, 1'b1);
            return;
        end
        pos = sum;
        while (pos > 0 && trail.size() < fewest[sum]) begin
            c = coin_val[pick[pos]];
            trail.push_back(c);
            pos = (c <= pos) ? pos - c : 0;
        end
        // traceback holds the final coin first
        for (i = trail.size() - 1; i >= 0; i--)
            add_item(COIN_W'(trail[i]), 1'b1, TGT_W'(fewest[sum]), i == 0);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        coin_item_t want;
        int bad;
        int k;
        if (!rst_n) begin
            coins_in_use <= CNT_W'(1);
            for (k = 0; k < NUM_COINS; k++)
                coin_val[k] <= COIN_W'(1);
            change_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            bad = 0;
            if (out_valid && out_ready) begin
                if (change_due.size() == 0) begin
                    $error("coin item with nothing expected: coin_value %0d last %0b",
                           coin_value, last);
                    bad++;
                end
                else begin
                    want = change_due.pop_front();
                    if (coin_value !== want.coin) begin
                        $error("coin_value: expected %0d, got %0d", want.coin, coin_value);
                        bad++;
                    end
                    if (found !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, found);
                        bad++;
                    end
                    if (sequence_length !== want.length) begin
                        $error("sequence_length: expected %0d, got %0d",
                               want.length, sequence_length);
                        bad++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        bad++;
                    end
                end
            end
            if (in_valid && in_ready)
                plan_change(target);
            if (cfg_wr_en) begin
                if (cfg_index == CFG_COIN_COUNT)
                    coins_in_use <= cfg_data[CNT_W-1:0];
                else if (cfg_index >= CFG_COIN_FIRST && cfg_index < CFG_COIN_FIRST + NUM_COINS)
                    coin_val[cfg_index - CFG_COIN_FIRST] <= cfg_data;
            end
            mismatches  <= mismatches + bad;
            outstanding <= change_due.size();
        end
    end

endmodule

### tb/tb_min_coin_change_sequence.sv
// Testbench top: drives queries, coin settings and output back-pressure, and gives the verdict.
`timescale 1ns / 100ps

module tb_min_coin_change_sequence;
    import mcc_pkg::*;

    localparam logic [IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int RANDOM_SETS = 6;
    localparam int SET_QUERIES = 50;

    typedef logic [COIN_W-1:0] coin_set_t [NUM_COINS];

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [TGT_W-1:0]  target;
    logic              out_valid;
    logic              out_ready;
    logic [COIN_W-1:0] coin_value;
    logic              found;
    logic [TGT_W-1:0]  sequence_length;
    logic              last;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [COIN_W-1:0] cfg_data;
    logic              hold_req;
    int                mismatches;
    int                outstanding;
    int                burst_left;

    min_coin_change_sequence dut (.*);

    mcc_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // worst case is well under 4 ms; allow several times that
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COIN_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_coins(input logic [COIN_W-1:0] count_word, input coin_set_t vals);
        int i;
        write_reg(CFG_COIN_COUNT, count_word);
        for (i = 0; i < NUM_COINS; i++)
            write_reg(IDX_W'(CFG_COIN_FIRST + i), vals[i]);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_target(input logic [TGT_W-1:0] sum);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        target   <= sum;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (burst_left == 0)
            in_valid <= 1'b0;
    endtask

    task automatic settle();
        if (burst_left != 0)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
        end
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_coins();
        coin_set_t vals;
        int style, i, count;
        style = $urandom_range(0, 3);
        for (i = 0; i < NUM_COINS; i++)
        begin
            case (style)
                0:       vals[i] = COIN_W'($urandom_range(1, 9));
                1:       vals[i] = COIN_W'($urandom_range(1, 63));
                2:       vals[i] = ($urandom_range(0, 4) == 0) ? '0
                                   : COIN_W'($urandom_range(2, 12));
                default: vals[i] = ($urandom_range(0, 1) == 0) ? COIN_W'(1) : COIN_W'(63);
            endcase
        end
        count = ($urandom_range(0, 5) == 0) ? 7 * $urandom_range(0, 1) : $urandom_range(1, 6);
        // upper bits of the count word are don't-care
        load_coins({3'($urandom_range(0, 7)), 3'(count)}, vals);
    endtask

    // receiver: random ready modes, plus one long hold-off on request
    initial
    begin : receiver
        int mode, mode_left, hold_left;
        bit hold_done;
        out_ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 600;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        coin_set_t vals;
        int s, q;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        target     = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one coin of value one
        send_target(6'd0);
        send_target(6'd1);
        send_target(6'd63);
        send_target(6'd5);
        settle();

        // greedy would pick 4 first here
        vals = '{6'd1, 6'd3, 6'd4, 6'd1, 6'd1, 6'd1};
        load_coins(6'd3, vals);
        send_target(6'd6);
        send_target(6'd7);
        send_target(6'd62);
        send_target(6'd2);
        settle();

        // spare index ignored, count saturates, zero coin unused, duplicate coins
        write_reg(CFG_SPARE, 6'd63);
        vals = '{6'd2, 6'd3, 6'd0, 6'd63, 6'd5, 6'd5};
        load_coins(6'd7, vals);
        send_target(6'd1);
        send_target(6'd63);
        send_target(6'd4);
        send_target(6'd7);
        settle();

        // no coins in use
        vals = '{default: 6'd63};
        load_coins(6'd0, vals);
        send_target(6'd0);
        send_target(6'd9);
        send_target(6'd63);
        settle();

        for (s = 0; s < RANDOM_SETS; s++)
        begin
            random_coins();
            for (q = 0; q < SET_QUERIES; q++)
            begin
                if (s == 1 && q == 10)
                    hold_req <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    send_target(TGT_W'($urandom_range(0, 63)));
                else
                    send_target(TGT_W'($urandom_range(0, 20)));
            end
            settle();
        end

        repeat (32) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
